// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/dcsfr_pkg.sv =====
// ---------------------------------------------------------------------------
// dcsfr_pkg
// Types and constants of the daisy-chain sync frame receiver.
// ---------------------------------------------------------------------------
package dcsfr_pkg;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 4;

    localparam int FRAME_LEN_DEF  = 15;
    localparam int SYNC_COUNT_DEF = 15;

    localparam logic [BYTE_W-1:0] RESYNC_BYTE_RST = 8'd27;
    localparam logic [BYTE_W-1:0] BCAST_ADDR_RST  = 8'd255;

    // configuration register indexes
    localparam logic CFG_RESYNC_BYTE = 1'b0;
    localparam logic CFG_BCAST_ADDR  = 1'b1;

    // result word kinds
    localparam logic KIND_FWD   = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  frame_index;
        logic              last;
        logic [BYTE_W-1:0] own_address;
    } t_result;

endpackage

// ===== rtl/dcsfr_rx_if.sv =====
// ---------------------------------------------------------------------------
// dcsfr_rx_if
// Input channel: one received byte per word, valid/ready handshake.
// ---------------------------------------------------------------------------
interface dcsfr_rx_if;
    import dcsfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/dcsfr_res_if.sv =====
// ---------------------------------------------------------------------------
// dcsfr_res_if
// Result channel: forwarded bytes and frame bytes, valid/ready handshake.
// ---------------------------------------------------------------------------
interface dcsfr_res_if;
    import dcsfr_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  frame_index;
    logic              last;
    logic [BYTE_W-1:0] own_address;

    modport source (output valid, output kind, output data_byte, output frame_index,
                    output last, output own_address, input ready);
    modport sink   (input valid, input kind, input data_byte, input frame_index,
                    input last, input own_address, output ready);
endinterface

// ===== rtl/daisy_chain_sync_frame_receiver.sv =====
// Latency: a received byte shows its forwarded word on the cycle after it is accepted.
// Throughput: one byte per cycle while the result side keeps up; a byte that completes
// an accepted frame holds input until the frame has been replayed, since the frame is
// read back from the single-port store one entry per cycle while the result side keeps up.
// Reset (synchronous, i_rst_n low): registers return to defaults, run, sync, address
// and fill count clear; frame store content is left as is.
// ---------------------------------------------------------------------------
// daisy_chain_sync_frame_receiver
// Resyncs on a run of resync bytes, captures the node address, buffers a frame
// and replays it when addressed to this node or to the broadcast address.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module daisy_chain_sync_frame_receiver #(
    parameter int FRAME_LEN  = dcsfr_pkg::FRAME_LEN_DEF,
    parameter int SYNC_COUNT = dcsfr_pkg::SYNC_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [dcsfr_pkg::BYTE_W-1:0] i_cfg_data,
    dcsfr_rx_if.sink                     i_rx,
    dcsfr_res_if.source                  o_res
);
    import dcsfr_pkg::*;

    localparam int AW = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0]  FRAME_LEN_V = IDX_W'(FRAME_LEN);
    localparam logic [IDX_W-1:0]  LAST_POS    = IDX_W'(FRAME_LEN - 1);
    localparam logic [BYTE_W-1:0] SYNC_RUN_V  = BYTE_W'(SYNC_COUNT);

    // configuration
    logic [BYTE_W-1:0] r_resync_byte;
    logic [BYTE_W-1:0] r_bcast_addr;

    // control state
    t_state            r_state, n_state;
    logic [BYTE_W-1:0] r_run, n_run;
    logic              r_synced, n_synced;
    logic [BYTE_W-1:0] r_node_addr, n_node_addr;
    logic [IDX_W-1:0]  r_fill, n_fill;
    logic [IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic              r_rd_valid, n_rd_valid;
    logic              r_out_valid, n_out_valid;

    // payload
    logic [BYTE_W-1:0] r_head;
    logic [BYTE_W-1:0] r_rd_data;
    logic [IDX_W-1:0]  r_rd_pos;
    t_result           r_out;

    logic [BYTE_W-1:0] mem [FRAME_LEN];

    logic              in_acc;
    logic              capture;
    logic              store;
    logic [IDX_W-1:0]  fill_after;
    logic              full;
    logic              emit;
    logic [BYTE_W-1:0] own_addr;
    logic [BYTE_W-1:0] fwd_byte;
    logic              load_frame;
    logic              rd_go;
    logic              mem_we;

    assign i_rx.ready = (r_state == ST_IDLE) && (!r_out_valid || o_res.ready);
    assign in_acc     = i_rx.valid && i_rx.ready;

    // per-byte decision
    always_comb begin
        capture    = (r_run == SYNC_RUN_V);
        store      = !capture && (r_fill < FRAME_LEN_V);
        n_synced   = r_synced | capture;
        n_node_addr = capture ? i_rx.rx_byte : r_node_addr;
        if (capture) begin
            fill_after = '0;
        end else if (store) begin
            fill_after = r_fill + IDX_W'(1);
        end else begin
            fill_after = r_fill;
        end
        full     = n_synced && (fill_after == FRAME_LEN_V);
        // byte 0 was stored on an earlier word, as a frame is at least two bytes
        emit     = full && ((r_head == n_node_addr) || (r_head == r_bcast_addr));
        own_addr = n_synced ? n_node_addr : '0;
        fwd_byte = capture ? (i_rx.rx_byte + BYTE_W'(1)) : i_rx.rx_byte;
        n_run    = (i_rx.rx_byte == r_resync_byte) ? (r_run + BYTE_W'(1)) : '0;
        n_fill   = full ? '0 : fill_after;
    end

    assign mem_we     = in_acc && store;
    assign load_frame = r_rd_valid && (!r_out_valid || o_res.ready);
    assign rd_go      = (r_state == ST_EMIT) && (r_rd_idx < FRAME_LEN_V)
                        && (!r_rd_valid || load_frame);

    always_comb begin
        n_state     = r_state;
        n_rd_idx    = r_rd_idx;
        n_rd_valid  = r_rd_valid;
        n_out_valid = r_out_valid;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && emit) begin
                    n_state  = ST_EMIT;
                    n_rd_idx = '0;
                end
            end
            ST_EMIT: begin
                if (load_frame && (r_rd_pos == LAST_POS)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (rd_go) begin
            n_rd_idx   = r_rd_idx + IDX_W'(1);
            n_rd_valid = 1'b1;
        end else if (load_frame) begin
            n_rd_valid = 1'b0;
        end
        if (in_acc || load_frame) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resync_byte <= RESYNC_BYTE_RST;
            r_bcast_addr  <= BCAST_ADDR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RESYNC_BYTE: r_resync_byte <= i_cfg_data;
                CFG_BCAST_ADDR:  r_bcast_addr  <= i_cfg_data;
                default: begin
                    r_resync_byte <= r_resync_byte;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_run       <= '0;
            r_synced    <= 1'b0;
            r_node_addr <= '0;
            r_fill      <= '0;
            r_rd_idx    <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
            if (in_acc) begin
                r_run       <= n_run;
                r_synced    <= n_synced;
                r_node_addr <= n_node_addr;
                r_fill      <= n_fill;
            end
        end
    end

    // frame store: written on accepted bytes that are stored, read back only during replay
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_fill[AW-1:0]] <= i_rx.rx_byte;
        end
        if (rd_go) begin
            r_rd_data <= mem[r_rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && (r_fill == '0)) begin
            r_head <= i_rx.rx_byte;
        end
        if (rd_go) begin
            r_rd_pos <= r_rd_idx;
        end
        if (in_acc) begin
            r_out.kind        <= KIND_FWD;
            r_out.data_byte   <= fwd_byte;
            r_out.frame_index <= '0;
            r_out.last        <= !emit;
            r_out.own_address <= own_addr;
        end else if (load_frame) begin
            r_out.kind        <= KIND_FRAME;
            r_out.data_byte   <= r_rd_data;
            r_out.frame_index <= r_rd_pos;
            r_out.last        <= (r_rd_pos == LAST_POS);
            r_out.own_address <= r_synced ? r_node_addr : '0;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_out.kind;
    assign o_res.data_byte   = r_out.data_byte;
    assign o_res.frame_index = r_out.frame_index;
    assign o_res.last        = r_out.last;
    assign o_res.own_address = r_out.own_address;

    `ASSERT_ALWAYS(a_no_input_in_replay, (r_state == ST_EMIT) |-> !i_rx.ready, "input taken during replay")
    `ASSERT_NEVER(a_fill_bound, r_fill > FRAME_LEN_V, "fill count beyond frame length")
    `ASSERT_NEVER(a_store_port, mem_we && rd_go, "store written and read in one cycle")
    `ASSERT_ALWAYS(a_frame_order, (o_res.valid && o_res.ready && o_res.kind && !o_res.last) |=> (!o_res.valid || (o_res.kind && (o_res.frame_index == IDX_W'($past(o_res.frame_index) + 1'b1)))), "frame bytes out of order")

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives received bytes into the daisy-chain sync frame receiver, predicts the
// forwarded and replayed words per byte, and checks every result word in order.
// ---------------------------------------------------------------------------
module testbench;
    import dcsfr_pkg::*;

    class frame_rx_scoreboard;
        logic [BYTE_W-1:0] resync_byte;
        logic [BYTE_W-1:0] bcast_addr;
        logic [BYTE_W-1:0] run_len;
        logic [BYTE_W-1:0] node_addr;
        bit                synced;
        logic [IDX_W-1:0]  fill_cnt;
        logic [BYTE_W-1:0] frame_buf [FRAME_LEN_DEF];
        t_result           expected_words [$];
        int                errors;
        int                rx_bytes;
        int                words_seen;
        int                frames_replayed;
        int                syncs;

        function new();
            resync_byte     = RESYNC_BYTE_RST;
            bcast_addr      = BCAST_ADDR_RST;
            run_len         = '0;
            node_addr       = '0;
            synced          = 1'b0;
            fill_cnt        = '0;
            errors          = 0;
            rx_bytes        = 0;
            words_seen      = 0;
            frames_replayed = 0;
            syncs           = 0;
        endfunction

        function void set_reg(logic idx, logic [BYTE_W-1:0] value);
            if (idx == CFG_RESYNC_BYTE) begin
                resync_byte = value;
            end else begin
                bcast_addr = value;
            end
        endfunction

        // note an accepted byte and queue the words it causes
        function void take_rx_byte(logic [BYTE_W-1:0] rx);
            logic [BYTE_W-1:0] fwd;
            logic [BYTE_W-1:0] own;
            bit                hit;
            t_result           w;
            rx_bytes++;
            hit = 1'b0;
            if (run_len == BYTE_W'(SYNC_COUNT_DEF)) begin
                node_addr = rx;
                fwd       = rx + 8'd1;
                fill_cnt  = '0;
                synced    = 1'b1;
                syncs++;
            end else begin
                fwd = rx;
                if (fill_cnt < FRAME_LEN_DEF) begin
                    frame_buf[fill_cnt] = rx;
                    fill_cnt            = fill_cnt + 1'b1;
                end
            end
            run_len = (rx == resync_byte) ? run_len + 8'd1 : '0;
            if (synced && fill_cnt == FRAME_LEN_DEF) begin
                hit      = (frame_buf[0] == node_addr) || (frame_buf[0] == bcast_addr);
                fill_cnt = '0;
            end
            own = synced ? node_addr : '0;
            w = '{kind: KIND_FWD, data_byte: fwd, frame_index: '0, last: !hit,
                  own_address: own};
            expected_words.push_back(w);
            if (hit) begin
                frames_replayed++;
                for (int i = 0; i < FRAME_LEN_DEF; i++) begin
                    w = '{kind: KIND_FRAME, data_byte: frame_buf[i], frame_index: IDX_W'(i),
                          last: (i == FRAME_LEN_DEF - 1), own_address: own};
                    expected_words.push_back(w);
                end
            end
        endfunction

        function void cmp_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 100) begin
                    $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                end
            end
        endfunction

        function void check_word(t_result got);
            t_result want;
            words_seen++;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 100) begin
                    $error("result word with nothing expected: data_byte %0h", got.data_byte);
                end
                return;
            end
            want = expected_words.pop_front();
            cmp_field("kind", want.kind, got.kind);
            cmp_field("data_byte", want.data_byte, got.data_byte);
            cmp_field("frame_index", want.frame_index, got.frame_index);
            cmp_field("last", want.last, got.last);
            cmp_field("own_address", want.own_address, got.own_address);
        endfunction
    endclass

    localparam int FLEN        = FRAME_LEN_DEF;
    localparam int SYNC_RUN    = SYNC_COUNT_DEF;
    localparam int SETTLE      = FRAME_LEN_DEF + 4;
    localparam int PHASE_BYTES = 28;
    localparam int CYCLE_LIMIT = 500000;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic              cfg_idx;
    logic [BYTE_W-1:0] cfg_data;
    bit                no_idle;
    int                cycle_cnt = 0;
    frame_rx_scoreboard sb;

    dcsfr_rx_if  rx_ch ();
    dcsfr_res_if res_ch ();

    daisy_chain_sync_frame_receiver u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_rx       (rx_ch.sink),
        .o_res      (res_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: stall about 30% of cycles unless idling is off
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= no_idle || ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.kind        = res_ch.kind;
            got.data_byte   = res_ch.data_byte;
            got.frame_index = res_ch.frame_index;
            got.last        = res_ch.last;
            got.own_address = res_ch.own_address;
            sb.check_word(got);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_byte(logic [BYTE_W-1:0] b);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 30) begin
                rx_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        sb.take_rx_byte(b);
    endtask

    task automatic send_resync_run(int n);
        repeat (n) send_byte(sb.resync_byte);
    endtask

    task automatic send_frame(logic [BYTE_W-1:0] head);
        send_byte(head);
        repeat (FLEN - 1) send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    // hold input until every expected word has come, then let the block settle
    task automatic wait_words_done();
        rx_ch.valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [BYTE_W-1:0] resync, logic [BYTE_W-1:0] bcast);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_RESYNC_BYTE;
        cfg_data <= resync;
        sb.set_reg(CFG_RESYNC_BYTE, resync);
        @(posedge i_clk);
        cfg_idx  <= CFG_BCAST_ADDR;
        cfg_data <= bcast;
        sb.set_reg(CFG_BCAST_ADDR, bcast);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase();
        int                start;
        int                pick;
        logic [BYTE_W-1:0] head;
        start = sb.rx_bytes;
        send_resync_run(SYNC_RUN);
        send_byte(BYTE_W'($urandom_range(0, 255)));
        while (sb.rx_bytes - start < PHASE_BYTES) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                case ($urandom_range(0, 3))
                    0, 1: head = sb.node_addr;
                    2: head = sb.bcast_addr;
                    default: head = BYTE_W'($urandom_range(0, 255));
                endcase
                send_frame(head);
            end else if (pick < 15) begin
                // a run one short must not capture an address
                send_resync_run(($urandom_range(0, 2) == 0) ? SYNC_RUN - 1 : SYNC_RUN);
                send_byte($urandom_range(0, 1) ? sb.resync_byte
                                               : BYTE_W'($urandom_range(0, 255)));
            end else if (pick < 18) begin
                repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
            end else if (pick == 18) begin
                wait_words_done();
            end else begin
                repeat ($urandom_range(FLEN + 1, FLEN + 5)) begin
                    send_byte(BYTE_W'($urandom_range(0, 255)));
                end
            end
        end
        wait_words_done();
    endtask

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_RESYNC_BYTE;
        cfg_data      <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // overfill the buffer before sync, then capture address 0xFF (forwards as 0x00)
        send_byte(8'h00);
        send_byte(8'hFF);
        send_resync_run(SYNC_RUN);
        send_byte(8'hFF);
        send_byte(8'hFF);
        for (int k = 0; k < FLEN - 1; k++) begin
            send_byte(BYTE_W'(k * 37));
        end
        wait_words_done();

        // first phase runs with both sides never idling
        write_regs(8'h00, 8'h00);
        no_idle = 1'b1;
        run_phase();
        no_idle = 1'b0;
        write_regs(8'hFF, 8'hFF);
        run_phase();
        write_regs(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
        run_phase();
        write_regs(RESYNC_BYTE_RST, 8'h80);
        run_phase();

        $display("Run covered %0d received bytes and %0d result words, %0d address captures.",
                 sb.rx_bytes, sb.words_seen, sb.syncs);
        $display("%0d frames replayed across five register settings.", sb.frames_replayed);
        if (sb.errors == 0 && sb.expected_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== daisy_chain_sync_frame_receiver.f =====
+incdir+rtl
rtl/dcsfr_pkg.sv
rtl/dcsfr_rx_if.sv
rtl/dcsfr_res_if.sv
rtl/daisy_chain_sync_frame_receiver.sv
verif/testbench.sv
